### rtl/dtd_pkg.sv
// Package with payload types, radix constants and calendar helpers for the date/time difference core.
package dtd_pkg;

    // Borrow radices for each field of the subtraction chain.
    localparam logic [5:0] C_SEC_RADIX   = 6'd60;
    localparam logic [5:0] C_MIN_RADIX   = 6'd60;
    localparam logic [5:0] C_HOUR_RADIX  = 6'd24;
    localparam logic [5:0] C_MONTH_RADIX = 6'd12;

    // Month codes that need special lengths.
    localparam logic [3:0] C_FEB = 4'd2;
    localparam logic [3:0] C_APR = 4'd4;
    localparam logic [3:0] C_JUN = 4'd6;
    localparam logic [3:0] C_SEP = 4'd9;
    localparam logic [3:0] C_NOV = 4'd11;

    // Month lengths.
    localparam logic [4:0] C_LEN_LONG  = 5'd31;
    localparam logic [4:0] C_LEN_SHORT = 5'd30;
    localparam logic [4:0] C_LEN_FEB   = 5'd28;
    localparam logic [4:0] C_LEN_LEAP  = 5'd29;

    // Reciprocal of 100 scaled by 2^19; exact for every 14-bit year.
    localparam logic [26:0] C_RECIP_100 = 27'd5243;
    localparam int          C_RECIP_SH  = 19;
    localparam logic [13:0] C_CENTURY   = 14'd100;

    // One input transfer: two stamps.
    typedef struct packed {
        logic [13:0] a_year;
        logic [3:0]  a_month;
        logic [4:0]  a_day;
        logic [4:0]  a_hour;
        logic [5:0]  a_minute;
        logic [5:0]  a_second;
        logic [13:0] b_year;
        logic [3:0]  b_month;
        logic [4:0]  b_day;
        logic [4:0]  b_hour;
        logic [5:0]  b_minute;
        logic [5:0]  b_second;
    } t_dtd_in;

    // One result transfer: later stamp minus earlier stamp.
    typedef struct packed {
        logic [13:0] diff_years;
        logic [3:0]  diff_months;
        logic [4:0]  diff_days;
        logic [4:0]  diff_hours;
        logic [5:0]  diff_minutes;
        logic [5:0]  diff_seconds;
    } t_dtd_out;

    // Result of one borrow stage.
    typedef struct packed {
        logic       brw;
        logic [5:0] val;
    } t_sub;

    // Gregorian leap year test; the year is split by a reciprocal multiply by 1/100.
    function automatic logic f_leap(input logic [13:0] year);
        logic [26:0] prod;
        logic [7:0]  cent;
        logic [13:0] back;
        logic        div100;
        logic        div400;
        prod   = {13'd0, year} * C_RECIP_100;
        cent   = prod[26:C_RECIP_SH];
        back   = 14'({6'd0, cent} * C_CENTURY);
        div100 = (back == year);
        div400 = div100 && (cent[1:0] == 2'd0);
        return div400 || (!div100 && (year[1:0] == 2'd0));
    endfunction

    // Days in a month; codes outside 1 to 12 count as long months.
    function automatic logic [4:0] f_month_len(input logic [3:0] month, input logic [13:0] year);
        logic [4:0] len;
        case (month) inside
            C_APR, C_JUN, C_SEP, C_NOV: len = C_LEN_SHORT;
            C_FEB:                      len = f_leap(year) ? C_LEN_LEAP : C_LEN_FEB;
            default:                    len = C_LEN_LONG;
        endcase
        return len;
    endfunction

    // One borrow stage on values of up to six bits; callers truncate to their width.
    function automatic t_sub f_borrow_sub(input logic [5:0] hi, input logic [5:0] lo,
                                          input logic [5:0] radix, input logic brw_in);
        logic [6:0] diff;
        t_sub       res;
        diff    = {1'b0, hi} - {1'b0, lo} - {6'd0, brw_in};
        res.brw = diff[6];
        res.val = diff[6] ? (diff[5:0] + radix) : diff[5:0];
        return res;
    endfunction

endpackage

### rtl/dtd_calc.sv
// Combinational ordering and borrow-chain subtraction of two date/time stamps.
module dtd_calc (
    input  dtd_pkg::t_dtd_in  i_stamps,
    output dtd_pkg::t_dtd_out o_diff
);

    logic [39:0]     a_key;
    logic [39:0]     b_key;
    logic            a_later;
    logic [39:0]     hi;
    logic [39:0]     lo;
    logic [4:0]      day_radix;
    dtd_pkg::t_sub   s_sec;
    dtd_pkg::t_sub   s_min;
    dtd_pkg::t_sub   s_hour;
    dtd_pkg::t_sub   s_day;
    dtd_pkg::t_sub   s_mon;

    // Packing the fields in order makes one compare lexicographic; ties pick a.
    assign a_key = {i_stamps.a_year, i_stamps.a_month, i_stamps.a_day,
                    i_stamps.a_hour, i_stamps.a_minute, i_stamps.a_second};
    assign b_key = {i_stamps.b_year, i_stamps.b_month, i_stamps.b_day,
                    i_stamps.b_hour, i_stamps.b_minute, i_stamps.b_second};
    assign a_later = !(b_key > a_key);
    assign hi = a_later ? a_key : b_key;
    assign lo = a_later ? b_key : a_key;

    // Day borrows use the length of the earlier stamp's month.
    assign day_radix = dtd_pkg::f_month_len(lo[25:22], lo[39:26]);

    // Borrow chain from seconds up to months.
    assign s_sec  = dtd_pkg::f_borrow_sub(hi[5:0], lo[5:0], dtd_pkg::C_SEC_RADIX, 1'b0);
    assign s_min  = dtd_pkg::f_borrow_sub(hi[11:6], lo[11:6], dtd_pkg::C_MIN_RADIX,
                                          s_sec.brw);
    assign s_hour = dtd_pkg::f_borrow_sub({1'b0, hi[16:12]}, {1'b0, lo[16:12]},
                                          dtd_pkg::C_HOUR_RADIX, s_min.brw);
    assign s_day  = dtd_pkg::f_borrow_sub({1'b0, hi[21:17]}, {1'b0, lo[21:17]},
                                          {1'b0, day_radix}, s_hour.brw);
    assign s_mon  = dtd_pkg::f_borrow_sub({2'b0, hi[25:22]}, {2'b0, lo[25:22]},
                                          dtd_pkg::C_MONTH_RADIX, s_day.brw);

    // Years take the last borrow and wrap at 14 bits.
    assign o_diff.diff_years   = hi[39:26] - lo[39:26] - {13'd0, s_mon.brw};
    assign o_diff.diff_months  = s_mon.val[3:0];
    assign o_diff.diff_days    = s_day.val[4:0];
    assign o_diff.diff_hours   = s_hour.val[4:0];
    assign o_diff.diff_minutes = s_min.val;
    assign o_diff.diff_seconds = s_sec.val;

endmodule

### rtl/date_time_difference_core.sv
// Top level of the date/time difference core: input register, calculation, result register.
//
//   Channel   Ports                     Direction  Transfer when
//   command   i_start, i_in, o_busy     in         i_start high and o_busy low
//   result    o_done, o_result          out        o_done high (one cycle, no stall)
//
// A stamp pair is captured in the input register and its difference lands in the result
// register in the next cycle, one pair per cycle.
// The throughput is set by the single-pass borrow chain between the two registers.
// o_busy stays low, so a new command is taken in every cycle.
// Synchronous active-low reset clears both valid flags; payload registers are not reset.
// The receiver cannot stall; each result is shown for exactly one cycle.
module date_time_difference_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  dtd_pkg::t_dtd_in  i_in,
    output logic              o_busy,
    output logic              o_done,
    output dtd_pkg::t_dtd_out o_result
);

    logic              r_in_vld;
    logic              n_in_vld;
    dtd_pkg::t_dtd_in  r_in;
    logic              r_out_vld;
    dtd_pkg::t_dtd_out r_out;
    dtd_pkg::t_dtd_out calc_diff;
    logic              accept;

    // The pipeline never stalls, so a command is always taken.
    assign o_busy   = 1'b0;
    assign accept   = i_start && !o_busy;
    assign n_in_vld = accept;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= n_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_in;
        end
    end

    // Ordering and borrow subtraction.
    dtd_calc u_calc (
        .i_stamps (r_in),
        .o_diff   (calc_diff)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_vld) begin
            r_out <= calc_diff;
        end
    end

    assign o_done   = r_out_vld;
    assign o_result = r_out;

    // An accepted command fills the input register.
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_in_vld)
        else $error("accepted command did not reach the input register");

    // Every captured pair yields a result in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld |=> o_done)
        else $error("captured pair produced no result");

    // Results appear only for captured pairs.
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_in_vld))
        else $error("result strobe without a captured pair");

    // Equal stamps give an all-zero difference.
    a_equal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && (r_in.a_year == r_in.b_year) && (r_in.a_month == r_in.b_month)
         && (r_in.a_day == r_in.b_day) && (r_in.a_hour == r_in.b_hour)
         && (r_in.a_minute == r_in.b_minute) && (r_in.a_second == r_in.b_second))
        |=> (o_result == '0))
        else $error("equal stamps gave a nonzero difference");

endmodule
